// ----- hw/rtl/sesc_pkg.sv -----
// sesc_pkg: shared types, character codes and lookup functions for the
// string escape encoder. No dependencies.
package sesc_pkg;

   localparam int CHAR_W      = 21;
   localparam int LEN_W       = 16;
   localparam int COUNT_W     = 17;
   localparam int MAX_RESULTS = 5;
   localparam int RES_CNT_W   = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // item opcodes
   localparam logic OP_CHAR   = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   // configuration register indexes
   localparam logic REG_MAX_LENGTH = 1'b0;
   localparam logic REG_QUOTE_MODE = 1'b1;

   // character codes
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_CTRL_END = 8'h20;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_X      = 8'h78;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_V  = 8'h76;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              has_char;
      logic              end_of_string;
   } rsp_word_type;

   typedef struct packed {
      rsp_word_type [MAX_RESULTS-1:0] words;
      logic [RES_CNT_W-1:0]           count;
   } expand_type;

   typedef struct packed {
      logic               started;
      logic               after_hex;
      logic               truncated;
      logic [COUNT_W-1:0] count;
   } state_type;

   // upper-case hex digit for one nibble
   function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
      hex_ascii = (nib < 4'd10) ? (CH_ZERO + {4'd0, nib}) : (CH_UP_A + {4'd0, nib} - 8'd10);
   endfunction

   // letter of the short escape, zero when the character has none
   function automatic logic [7:0] esc_letter(input logic [CHAR_W-1:0] c);
      logic [7:0] r;
      r = 8'd0;
      if (c[CHAR_W-1:8] == '0) begin
         case (c[7:0])
            CH_BEL:    r = CH_LOW_A;
            CH_BS:     r = CH_LOW_B;
            CH_FF:     r = CH_LOW_F;
            CH_LF:     r = CH_LOW_N;
            CH_CR:     r = CH_LOW_R;
            CH_TAB:    r = CH_LOW_T;
            CH_VT:     r = CH_LOW_V;
            CH_BSLASH: r = CH_BSLASH;
            CH_SQUOTE: r = CH_SQUOTE;
            CH_DQUOTE: r = CH_DQUOTE;
            default:   r = 8'd0;
         endcase
      end
      esc_letter = r;
   endfunction

   function automatic logic is_hex_char(input logic [CHAR_W-1:0] c);
      logic hi_zero;
      hi_zero = (c[CHAR_W-1:8] == '0);
      is_hex_char = hi_zero &&
                    ((c[7:0] >= CH_ZERO  && c[7:0] <= CH_NINE)  ||
                     (c[7:0] >= CH_UP_A  && c[7:0] <= CH_UP_F)  ||
                     (c[7:0] >= CH_LOW_A && c[7:0] <= CH_LOW_F));
   endfunction

endpackage

// ----- hw/rtl/string_escape_encoder.sv -----
// string_escape_encoder: top level of the C-style string escaper.
// Depends on sesc_pkg, sesc_expand and sesc_drain.
//
// A string comes in one code point per word (req_op = 0) and is closed by a
// finish word (req_op = 1). Each code point leaves as its C escape, one
// character per result word: \a \b \f \n \r \t \v, backslash and both
// quotes get the two-character form, other control codes below 0x20 and a
// hex digit right after a \xHH escape become \xHH. With quote mode on, the
// string is wrapped in double quotes, and once max_length characters have
// gone out the rest is dropped behind " ..." without a closing quote. The
// finish word's last result carries end_of_string; if it has nothing to
// print it gives one empty result (has_char = 0). An input word is
// expanded in the cycle it is accepted and its 0 to 5 characters wait in a
// small word queue that feeds the result register one word per cycle while
// the output is ready, so each result passes through the queue and then
// the result register. The result channel sets the rate: a new word waits
// at the input while earlier words still fill the queue. The next word is
// accepted in the same cycle the queue's last word moves to the result
// register, so there are no gaps while the output is ready. Configuration
// writes land at once and apply from the next accepted word.
module string_escape_encoder import sesc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // input words
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_op,
   input  logic [CHAR_W-1:0] req_code_point,
   // result words
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_out_char,
   output logic              rsp_has_char,
   output logic              rsp_end_of_string,
   // configuration writes
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [LEN_W-1:0]  csr_wdata
);

   logic [LEN_W-1:0] max_length_ff, max_length_in;
   logic             quote_mode_ff, quote_mode_in;
   state_type        state_ff, state_in;
   state_type        state_calc;
   expand_type       expansion;
   rsp_word_type     rsp_word;
   logic             req_accept;

   assign req_accept = req_valid && req_ready;

   // register file: decode the write index
   always_comb begin
      max_length_in = max_length_ff;
      quote_mode_in = quote_mode_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_MAX_LENGTH: max_length_in = csr_wdata;
            REG_QUOTE_MODE: quote_mode_in = csr_wdata[0];
            default:        max_length_in = max_length_ff;
         endcase
      end
   end

   // expand the incoming word against the current string state
   sesc_expand u_expand (
      .op         (req_op),
      .code_point (req_code_point),
      .state      (state_ff),
      .max_length (max_length_ff),
      .quote_mode (quote_mode_ff),
      .expansion  (expansion),
      .state_next (state_calc)
   );

   // advance the string state only on an accepted word
   assign state_in = req_accept ? state_calc : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= '1;
         quote_mode_ff <= 1'b0;
         state_ff      <= '0;
      end else begin
         max_length_ff <= max_length_in;
         quote_mode_ff <= quote_mode_in;
         state_ff      <= state_in;
      end
   end

   // queue the expanded words and drive the result channel
   sesc_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .load       (req_accept),
      .expansion  (expansion),
      .load_ready (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_word   (rsp_word)
   );

   assign rsp_out_char      = rsp_word.out_char;
   assign rsp_has_char      = rsp_word.has_char;
   assign rsp_end_of_string = rsp_word.end_of_string;

`ifndef ASSERT_OFF
   a_trunc_started: assert property (@(posedge clock) disable iff (reset)
      state_ff.truncated |-> state_ff.started)
      else $error("truncated outside a string");
   a_hex_started: assert property (@(posedge clock) disable iff (reset)
      state_ff.after_hex |-> state_ff.started)
      else $error("hex escape flag outside a string");
   a_finish_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_op == OP_FINISH) |=> (state_ff == '0))
      else $error("string state not cleared after finish");
`endif

endmodule

// ----- hw/rtl/sesc_expand.sv -----
// sesc_expand: turns one input word and the string state into the list of
// output words and the next state. Depends on sesc_pkg.
module sesc_expand import sesc_pkg::*; (
   input  logic              op,
   input  logic [CHAR_W-1:0] code_point,
   input  state_type         state,
   input  logic [LEN_W-1:0]  max_length,
   input  logic              quote_mode,
   output expand_type        expansion,
   output state_type         state_next
);

   logic                   open_quote;
   logic [COUNT_W-1:0]     base_count;
   logic [7:0]             esc;
   logic                   hex_path;
   logic                   hit_limit;
   logic [CHAR_W-1:0]      body [4];
   logic [RES_CNT_W-1:0]   body_n;
   logic [RES_CNT_W-1:0]   total;
   logic [RES_CNT_W-1:0]   count_out;
   logic [CHAR_W-1:0]      chars [MAX_RESULTS];
   logic [COUNT_W:0]       sum;

   assign open_quote = !state.started && quote_mode;
   assign base_count = (open_quote && state.count != COUNT_MAX) ?
                       state.count + COUNT_W'(1) : state.count;
   assign esc        = esc_letter(code_point);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         body[i] = '0;
      end
      body_n    = '0;
      hex_path  = 1'b0;
      hit_limit = 1'b0;
      if (op == OP_FINISH) begin
         if (!state.truncated && quote_mode) begin
            body[0] = CHAR_W'(CH_DQUOTE);
            body_n  = 3'd1;
         end
      end else if (!state.truncated) begin
         if (base_count >= {1'b0, max_length}) begin
            hit_limit = 1'b1;
            if (quote_mode) begin
               body[0] = CHAR_W'(CH_SPACE);
               body[1] = CHAR_W'(CH_DOT);
               body[2] = CHAR_W'(CH_DOT);
               body[3] = CHAR_W'(CH_DOT);
               body_n  = 3'd4;
            end
         end else if (esc != 8'd0) begin
            body[0] = CHAR_W'(CH_BSLASH);
            body[1] = CHAR_W'(esc);
            body_n  = 3'd2;
         end else if ((state.after_hex && is_hex_char(code_point)) ||
                      (code_point < CHAR_W'(CH_CTRL_END))) begin
            hex_path = 1'b1;
            body[0]  = CHAR_W'(CH_BSLASH);
            body[1]  = CHAR_W'(CH_X);
            body[2]  = CHAR_W'(hex_ascii(code_point[7:4]));
            body[3]  = CHAR_W'(hex_ascii(code_point[3:0]));
            body_n   = 3'd4;
         end else begin
            body[0] = code_point;
            body_n  = 3'd1;
         end
      end
   end

   assign total     = body_n + {2'd0, open_quote};
   // a finish with nothing to print still closes the string with an empty word
   assign count_out = (op == OP_FINISH && total == '0) ? 3'd1 : total;

   always_comb begin
      chars[0] = open_quote ? CHAR_W'(CH_DQUOTE) : body[0];
      for (int k = 1; k < 4; k++) begin
         chars[k] = open_quote ? body[k-1] : body[k];
      end
      chars[4] = open_quote ? body[3] : '0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         expansion.words[i].has_char      = (RES_CNT_W'(i) < total);
         expansion.words[i].out_char      = (RES_CNT_W'(i) < total) ? chars[i] : '0;
         expansion.words[i].end_of_string = (op == OP_FINISH) &&
                                            (RES_CNT_W'(i) == count_out - 3'd1);
      end
      expansion.count = count_out;
   end

   assign sum = {1'b0, base_count} + {{(COUNT_W-2){1'b0}}, body_n};

   always_comb begin
      if (op == OP_FINISH) begin
         state_next = '0;
      end else begin
         state_next.started   = 1'b1;
         state_next.truncated = state.truncated | hit_limit;
         state_next.after_hex = (state.truncated || hit_limit) ? state.after_hex : hex_path;
         state_next.count     = sum[COUNT_W] ? COUNT_MAX : sum[COUNT_W-1:0];
      end
   end

endmodule

// ----- hw/rtl/sesc_drain.sv -----
// sesc_drain: holds the expanded words of one item and hands them out one
// per cycle through the result register while it is not stalled. Depends on sesc_pkg.
module sesc_drain import sesc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  expand_type   expansion,
   output logic         load_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   rsp_word_type [MAX_RESULTS-1:0] buf_ff, buf_in;
   logic [RES_CNT_W-1:0]           cnt_ff, cnt_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_word_type                   rsp_word_ff, rsp_word_in;
   logic                           out_open;
   logic                           pop;

   assign out_open   = !rsp_valid_ff || rsp_ready;
   assign pop        = (cnt_ff != '0) && out_open;
   assign load_ready = (cnt_ff == '0) || (cnt_ff == 3'd1 && pop);

   always_comb begin
      buf_in = buf_ff;
      cnt_in = cnt_ff;
      if (load) begin
         buf_in = expansion.words;
         cnt_in = expansion.count;
      end else if (pop) begin
         // advance the queue by one word
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            buf_in[i] = buf_ff[i+1];
         end
         cnt_in = cnt_ff - 3'd1;
      end
   end

   assign rsp_valid_in = pop ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   assign rsp_word_in  = pop ? buf_ff[0] : rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff      <= buf_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

`ifndef ASSERT_OFF
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RES_CNT_W'(MAX_RESULTS))
      else $error("word queue holds more than five words");
   a_load_room: assert property (@(posedge clock) disable iff (reset)
      load |-> (cnt_ff == '0 || (cnt_ff == 3'd1 && pop)))
      else $error("queue loaded while words still wait");
   a_no_ghost: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == '0 && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result shown with empty queue");
`endif

endmodule
